// File: sv/crc16ws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crc16ws_pkg;

  localparam int unsigned CrcWidth  = 16;
  localparam int unsigned WordWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  // register index, taken from paddr[2]
  localparam logic CrcSeedIdx = 1'b0;

  typedef logic [CrcWidth-1:0] crc_t;

  typedef struct packed {
    logic [WordWidth-1:0] data_word;
    logic                 start_req;
  } in_item_t;

  typedef struct packed {
    logic [CrcWidth-1:0]  crc_value;
    logic [WordWidth-1:0] last_word;
  } out_item_t;

  localparam crc_t BitPosConst [ByteWidth] = '{
    16'hC0C1, 16'hC181, 16'hC301, 16'hC601,
    16'hCC01, 16'hD801, 16'hF001, 16'hA001
  };

  function automatic crc_t crc_feed_byte(input crc_t crc_in, input logic [ByteWidth-1:0] byte_in);
    crc_t crc;
    logic hit;
    crc = crc_in;
    for (int k = 0; k < ByteWidth; k++) begin
      hit = crc[0] ^ byte_in[k];
      crc = crc >> 1;
      if (hit) begin
        crc = crc ^ BitPosConst[k];
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: sv/crc16ws_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module crc16ws_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [crc16ws_pkg::AddrWidth-1:0]   paddr,
  input  wire logic [crc16ws_pkg::DataWidth-1:0]   pwdata,
  output logic      [crc16ws_pkg::DataWidth-1:0]   prdata,
  output logic                                     pready,
  output crc16ws_pkg::crc_t                        seed_o
);

  crc16ws_pkg::crc_t seed_q, seed_d;
  logic              seed_hit;

  assign seed_hit = (paddr[2] == crc16ws_pkg::CrcSeedIdx);
  assign pready   = 1'b1;

  always_comb begin
    seed_d = seed_q;
    if (psel && penable && pwrite && seed_hit) begin
      seed_d = pwdata[crc16ws_pkg::CrcWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (seed_hit) begin
      prdata = {{(crc16ws_pkg::DataWidth-crc16ws_pkg::CrcWidth){1'b0}}, seed_q};
    end
  end

  assign seed_o = seed_q;

endmodule

`default_nettype wire

// File: sv/crc16ws_step.sv
`timescale 1ns / 1ps
`default_nettype none

module crc16ws_step (
  input  wire crc16ws_pkg::crc_t     crc_i,
  input  wire crc16ws_pkg::crc_t     seed_i,
  input  wire crc16ws_pkg::in_item_t item_i,
  output crc16ws_pkg::crc_t          crc_o
);

  crc16ws_pkg::crc_t crc_start;
  crc16ws_pkg::crc_t crc_mid;

  assign crc_start = item_i.start_req ? seed_i : crc_i;
  // low byte first, then high byte
  assign crc_mid   = crc16ws_pkg::crc_feed_byte(crc_start, item_i.data_word[7:0]);
  assign crc_o     = crc16ws_pkg::crc_feed_byte(crc_mid, item_i.data_word[15:8]);

endmodule

`default_nettype wire

// File: sv/crc16_word_stream_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// CRC-16 (reflected, poly 0x8005 family) over a stream of 16-bit words.
// Input channel: in_valid_i / in_ready_o carry in_data_i (data_word,
// start_req). start_req reloads the running CRC from the seed register
// before the word is folded in, low byte first, LSB first.
// Output channel: out_valid_o / out_ready_i carry out_data_o (crc_value,
// last_word), one transaction per input transaction, in order.
// Configuration: APB register 0 (byte address 0) is the 16-bit seed.
// Path: a word taken in is held in the input register, then the two-byte
// CRC fold lands in the output register.
// Throughput: one word per cycle while the receiver does not stall; the
// 16 unrolled bit steps sit between the input register and the output register.
// Receiver stall: the output register holds its transaction; one more
// word is taken into the input register, then in_ready_o drops.
// Reset: both stages empty, running CRC and seed cleared to zero.

module crc16_word_stream_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire crc16ws_pkg::in_item_t               in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output crc16ws_pkg::out_item_t                   out_data_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [crc16ws_pkg::AddrWidth-1:0]   paddr,
  input  wire logic [crc16ws_pkg::DataWidth-1:0]   pwdata,
  output logic      [crc16ws_pkg::DataWidth-1:0]   prdata,
  output logic                                     pready
);

  crc16ws_pkg::crc_t      seed;
  crc16ws_pkg::crc_t      crc_q, crc_d;
  crc16ws_pkg::crc_t      crc_next;
  crc16ws_pkg::in_item_t  in_item_q;
  crc16ws_pkg::out_item_t out_item_q;
  logic                   in_valid_q, in_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic                   advance;
  logic                   in_take;

  crc16ws_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed_o  (seed)
  );

  crc16ws_step u_step (
    .crc_i  (crc_q),
    .seed_i (seed),
    .item_i (in_item_q),
    .crc_o  (crc_next)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    crc_d       = crc_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      crc_d       = crc_next;
      in_valid_d  = 1'b0;
    end
    if (in_take) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      crc_q       <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q.crc_value <= crc_next;
      out_item_q.last_word <= in_item_q.data_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

`default_nettype wire

// File: sv/crc16ws_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module crc16ws_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire crc16ws_pkg::in_item_t  in_data_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire crc16ws_pkg::out_item_t out_data_o
);

  // stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // input side only backs up when the output register is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a word taken in moves to the output once the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 (!out_valid_o || out_ready_i)
      |=> out_valid_o && (out_data_o.last_word == $past(in_data_i.data_word, 2)))
    else $error("word not echoed on output");

endmodule

bind crc16_word_stream_unit crc16ws_checker u_crc16ws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: tb/sv/tb_crc16_word_stream_unit.sv
`timescale 1ns / 1ps

module tb_crc16_word_stream_unit;

  localparam int unsigned CycleLimit   = 600_000;
  localparam int unsigned TargetWords  = 1900;
  localparam int unsigned RegUnmapped  = 1;
  localparam int unsigned MaxPrinted   = 30;
  localparam int unsigned AddrWidth    = crc16ws_pkg::AddrWidth;
  localparam int unsigned DataWidth    = crc16ws_pkg::DataWidth;

  // per bit position within a byte
  localparam logic [15:0] FoldMask [8] = '{
    16'hC0C1, 16'hC181, 16'hC301, 16'hC601,
    16'hCC01, 16'hD801, 16'hF001, 16'hA001
  };

  typedef enum int {SrcBackToBack, SrcMixed, SrcSparse} src_mode_e;
  typedef enum int {SinkAlways, SinkChoppy, SinkBursty} sink_mode_e;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  crc16ws_pkg::in_item_t  in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b1;
  crc16ws_pkg::out_item_t out_data;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [AddrWidth-1:0]   paddr = '0;
  logic [DataWidth-1:0]   pwdata = '0;
  logic [DataWidth-1:0]   prdata;
  logic                   pready;

  src_mode_e    src_mode = SrcMixed;
  sink_mode_e   sink_mode = SinkChoppy;
  int unsigned  stall_left = 0;
  int unsigned  cycle_count = 0;
  int unsigned  err_count = 0;
  int unsigned  words_sent = 0;

  logic [15:0]            seed_shadow = '0;
  logic [15:0]            running_crc = '0;
  crc16ws_pkg::out_item_t crc_expected [$];

  crc16_word_stream_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [15:0] fold_word(input logic [15:0] crc, input logic [15:0] word);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 16; i++) begin
      fb = c[0] ^ word[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ FoldMask[i % 8];
      end
    end
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    case (src_mode)
      SrcBackToBack: begin
        return 0;
      end
      SrcMixed: begin
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
      end
      default: begin
        if (r < 30) return 0;
        if (r < 85) return $urandom_range(4, 1);
        return $urandom_range(25, 5);
      end
    endcase
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
    end
  endtask

  // receiver side: stall pattern depends on sink_mode
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      case (sink_mode)
        SinkAlways: begin
          out_ready <= 1'b1;
        end
        SinkChoppy: begin
          if ($urandom_range(99) < 30) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(2, 0);
          end else begin
            out_ready <= 1'b1;
          end
        end
        default: begin
          if ($urandom_range(99) < 4) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(40, 10);
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    crc16ws_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (crc_expected.size() == 0) begin
        report_mismatch("unexpected transaction", out_data, '0);
      end else begin
        want = crc_expected.pop_front();
        if (out_data.crc_value !== want.crc_value) begin
          report_mismatch("crc_value", out_data.crc_value, want.crc_value);
        end
        if (out_data.last_word !== want.last_word) begin
          report_mismatch("last_word", out_data.last_word, want.last_word);
        end
      end
    end
  end

  task automatic send_word(input logic [15:0] word, input logic start);
    int unsigned            gap;
    crc16ws_pkg::out_item_t want;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_word: word, start_req: start};
    do @(posedge clk); while (!in_ready);
    if (start) begin
      running_crc = seed_shadow;
    end
    running_crc = fold_word(running_crc, word);
    want.crc_value = running_crc;
    want.last_word = word;
    crc_expected.push_back(want);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (crc_expected.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [AddrWidth-1:0] addr,
                            input logic [DataWidth-1:0] wdata,
                            output logic [DataWidth-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic write_reg(input int unsigned idx, input logic [DataWidth-1:0] value);
    logic [DataWidth-1:0] rd;
    logic [AddrWidth-1:0] addr;
    addr = AddrWidth'(idx * 4);
    apb_access(1'b1, addr, value, rd);
    if (idx == int'(crc16ws_pkg::CrcSeedIdx)) begin
      seed_shadow = value[15:0];
    end
    apb_access(1'b0, AddrWidth'(int'(crc16ws_pkg::CrcSeedIdx) * 4), '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (rd[15:0] !== seed_shadow) begin
      report_mismatch("seed readback", rd[15:0], seed_shadow);
    end
  endtask

  task automatic test_after_reset();
    src_mode  = SrcBackToBack;
    sink_mode = SinkAlways;
    // no start: CRC continues from the cleared running value
    send_word(16'h0000, 1'b0);
    send_word(16'hA5C3, 1'b0);
    send_word(16'hFFFF, 1'b0);
    wait_idle();
  endtask

  task automatic test_word_extremes();
    src_mode  = SrcMixed;
    sink_mode = SinkChoppy;
    write_reg(int'(crc16ws_pkg::CrcSeedIdx), 32'h0000_FFFF);
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h00FF, 1'b1);
    send_word(16'hFF00, 1'b0);
    send_word(16'hFFFF, 1'b1);
    send_word(16'h5555, 1'b1);
    send_word(16'hAAAA, 1'b0);
    wait_idle();
  endtask

  task automatic test_seed_midstream();
    src_mode  = SrcSparse;
    sink_mode = SinkBursty;
    write_reg(int'(crc16ws_pkg::CrcSeedIdx), 32'h0000_0000);
    send_word(16'h1234, 1'b1);
    send_word(16'hFEDC, 1'b0);
    wait_idle();
    write_reg(int'(crc16ws_pkg::CrcSeedIdx), 32'hFFFF_BEEF);
    send_word(16'h0F0F, 1'b0);
    send_word(16'hF0F0, 1'b1);
    wait_idle();
  endtask

  task automatic test_unmapped_write();
    src_mode  = SrcMixed;
    sink_mode = SinkChoppy;
    write_reg(RegUnmapped, 32'h0000_C0DE);
    send_word(16'h4321, 1'b1);
    send_word(16'h8001, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned phase_words;
    int unsigned len;
    phase = 0;
    while (words_sent < TargetWords) begin
      src_mode  = src_mode_e'($urandom_range(2));
      sink_mode = sink_mode_e'($urandom_range(2));
      case (phase)
        0: write_reg(int'(crc16ws_pkg::CrcSeedIdx), 32'h0000_0000);
        1: write_reg(int'(crc16ws_pkg::CrcSeedIdx), 32'h0000_FFFF);
        default: write_reg(int'(crc16ws_pkg::CrcSeedIdx), $urandom);
      endcase
      if ($urandom_range(5) == 0) begin
        write_reg(RegUnmapped, $urandom);
      end
      phase_words = 0;
      while (phase_words < 160) begin
        if ($urandom_range(99) < 85) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
          for (int i = 0; i < len; i++) begin
            send_word(rand_word(), i == 0);
          end
          phase_words += len;
        end else begin
          send_word(rand_word(), 1'($urandom));
          phase_words++;
        end
      end
      wait_idle();
      phase++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_word_extremes();
    test_seed_midstream();
    test_unmapped_write();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
